// ===== rtl/lmts_pkg.sv =====
package lmts_pkg;

  // Display modes as reported on the result channel
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LCD_ON       = 2'd0;
  localparam logic [1:0] CFG_LINE_COMPARE = 2'd1;
  localparam logic [1:0] CFG_IRQ_ENABLES  = 2'd2;

  // Interrupt enable bit positions
  localparam int IRQ_EN_HBLANK = 0;
  localparam int IRQ_EN_VBLANK = 1;
  localparam int IRQ_EN_OAM    = 2;
  localparam int IRQ_EN_MATCH  = 3;

  // Mode lengths, compared against the mode clock
  localparam logic [9:0] LEN_OAM    = 10'd80;
  localparam logic [9:0] LEN_XFER   = 10'd172;
  localparam logic [9:0] LEN_HBLANK = 10'd204;
  localparam logic [9:0] LEN_VLINE  = 10'd456;
  localparam logic [9:0] CLOCK_MAX  = 10'd1023;

  // Sequencer state carried from item to item
  typedef struct packed {
    mode_t      mode;
    logic [7:0] line;
    logic [9:0] clock;
    logic       match;
  } seq_state_t;

  // Per-item event flags
  typedef struct packed {
    logic vblank_irq;
    logic stat_irq;
    logic refreshed;
  } seq_flags_t;

endpackage

// ===== rtl/lmts_step.sv =====
module lmts_step #(
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  lmts_pkg::seq_state_t cur,
  input  logic                 lcd_on,
  input  logic [7:0]           line_compare,
  input  logic [3:0]           irq_enables,
  input  logic [6:0]           cycles,
  output lmts_pkg::seq_state_t nxt,
  output lmts_pkg::seq_flags_t flags
);

  localparam logic [7:0] VisLine  = 8'(VISIBLE_LINES);
  localparam logic [8:0] LastLine = 9'(LAST_LINE);

  logic [10:0] sum;
  logic [9:0]  clk_sat;
  logic [9:0]  len;
  logic [8:0]  line_inc;
  logic        match;

  // Add elapsed cycles, saturate, pick current mode length
  always_comb begin
    sum      = {1'b0, cur.clock} + {4'd0, cycles};
    clk_sat  = sum[10] ? lmts_pkg::CLOCK_MAX : sum[9:0];
    line_inc = {1'b0, cur.line} + 9'd1;
    case (cur.mode)
      lmts_pkg::MODE_OAM:    len = lmts_pkg::LEN_OAM;
      lmts_pkg::MODE_XFER:   len = lmts_pkg::LEN_XFER;
      lmts_pkg::MODE_HBLANK: len = lmts_pkg::LEN_HBLANK;
      default:               len = lmts_pkg::LEN_VLINE;
    endcase
  end

  // Take at most one transition and refresh status on it
  always_comb begin
    nxt   = cur;
    flags = '0;
    match = 1'b0;
    if (lcd_on) begin
      nxt.clock = clk_sat;
      if (clk_sat >= len) begin
        nxt.clock       = clk_sat - len;
        flags.refreshed = 1'b1;
        case (cur.mode)
          lmts_pkg::MODE_OAM:  nxt.mode = lmts_pkg::MODE_XFER;
          lmts_pkg::MODE_XFER: nxt.mode = lmts_pkg::MODE_HBLANK;
          lmts_pkg::MODE_HBLANK: begin
            nxt.line = line_inc[7:0];
            if (line_inc[7:0] == VisLine) begin
              nxt.mode         = lmts_pkg::MODE_VBLANK;
              flags.vblank_irq = 1'b1;
            end else begin
              nxt.mode = lmts_pkg::MODE_OAM;
            end
          end
          default: begin
            if (line_inc > LastLine) begin
              nxt.line = 8'd0;
              nxt.mode = lmts_pkg::MODE_OAM;
            end else begin
              nxt.line = line_inc[7:0];
            end
          end
        endcase
        match     = (nxt.line == line_compare);
        nxt.match = match;
        flags.stat_irq =
          (match && irq_enables[lmts_pkg::IRQ_EN_MATCH]) ||
          (nxt.mode == lmts_pkg::MODE_HBLANK && irq_enables[lmts_pkg::IRQ_EN_HBLANK]) ||
          (nxt.mode == lmts_pkg::MODE_VBLANK && irq_enables[lmts_pkg::IRQ_EN_VBLANK]) ||
          (nxt.mode == lmts_pkg::MODE_OAM && irq_enables[lmts_pkg::IRQ_EN_OAM]);
      end
    end
  end

endmodule

// ===== rtl/lcd_mode_timing_sequencer_core.sv =====
// LCD mode and scanline timing sequencer.
// Input stream: each request carries in_tdata[6:0] = time elapsed since
// the previous request. While the display is enabled the block advances its
// mode clock and steps OAM scan, pixel transfer, HBlank and VBlank, taking at
// most one transition per request; excess cycles carry over.
// Output stream: one result per input request, out_tdata holding line, mode,
// coincidence flag, VBlank and STAT interrupt requests and a refresh flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 display
// enable, 1 line compare, 2 interrupt enables); write only while idle.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; the update is one add, a saturate, one
// compare and subtract in the step logic between state and output register.
// When the receiver stalls, the result register holds and in_tready stays high
// only if the held result is taken in the same cycle.
// Reset (rst_n low, synchronous): mode OAM scan, line 0, mode clock 0,
// coincidence 0, all configuration registers 0, output empty.
module lcd_mode_timing_sequencer_core #(
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] cycles, [7] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] line, [9:8] mode, [10] coincidence,
                                  // [11] vblank_irq, [12] stat_irq,
                                  // [13] status_refreshed, [15:14] zero
);

  logic                 lcd_on_r;
  logic [7:0]           line_compare_r;
  logic [3:0]           irq_enables_r;
  lmts_pkg::seq_state_t state_r;
  lmts_pkg::seq_state_t state_nxt;
  lmts_pkg::seq_flags_t flags_nxt;
  lmts_pkg::seq_flags_t flags_r;
  logic                 out_valid_r;
  logic                 in_accept;

  // Accept when the result register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_on_r       <= 1'b0;
      line_compare_r <= 8'd0;
      irq_enables_r  <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmts_pkg::CFG_LCD_ON:       lcd_on_r       <= cfg_wdata[0];
        lmts_pkg::CFG_LINE_COMPARE: line_compare_r <= cfg_wdata;
        lmts_pkg::CFG_IRQ_ENABLES:  irq_enables_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  lmts_step #(
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_step (
    .cur          (state_r),
    .lcd_on       (lcd_on_r),
    .line_compare (line_compare_r),
    .irq_enables  (irq_enables_r),
    .cycles       (in_tdata[6:0]),
    .nxt          (state_nxt),
    .flags        (flags_nxt)
  );

  // Advance sequencer state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode  <= lmts_pkg::MODE_OAM;
      state_r.line  <= 8'd0;
      state_r.clock <= 10'd0;
      state_r.match <= 1'b0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // Capture event flags with the result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      flags_r <= flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, flags_r.refreshed, flags_r.stat_irq, flags_r.vblank_irq,
                       state_r.match, state_r.mode, state_r.line};

`ifndef ASSERT_OFF
  // State moves only on an accepted request
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(state_r))
    else $error("sequencer state changed without a request");

  // VBlank request only on entry to the first VBlank line with a refresh
  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && flags_r.vblank_irq) |->
      (flags_r.refreshed && state_r.mode == lmts_pkg::MODE_VBLANK &&
       state_r.line == 8'(VISIBLE_LINES)))
    else $error("vblank request without entering vblank");

  // STAT request requires a status refresh
  a_stat_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && flags_r.stat_irq) |-> flags_r.refreshed)
    else $error("stat request without status refresh");

  // Display off produces no events
  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !lcd_on_r) |=> (!flags_r.refreshed && $stable(state_r)))
    else $error("event while display off");
`endif

endmodule
